@@ sv/spist_pkg.sv @@
// Package with shared types, codes and constants for the transaction engine.
`timescale 1ns / 1ps

package spist_pkg;

  // Payload buffer depth; the buffer address is taken as the low bits of an index.
  localparam int PAYLOAD_DEPTH = 256;
  localparam int PBUF_AW       = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  // Item commands
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_RX    = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_PERR  = 3'd3;
  localparam logic [2:0] CMD_LOAD  = 3'd4;

  // Armed command kinds
  localparam logic [1:0] KIND_END   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  // Bus bytes
  localparam logic [7:0] TYPE_REQUEST  = 8'h50;
  localparam logic [7:0] TYPE_RESPONSE = 8'h51;
  localparam logic [7:0] CMD_BYTE_BASE = 8'hA0;
  localparam logic [7:0] NULL_BYTE     = 8'h00;

  // Status codes
  localparam logic [1:0] ST_OPEN = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TYPE    = 3'd1;
  localparam logic [2:0] ERR_PIN     = 3'd2;
  localparam logic [2:0] ERR_IDLE    = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_RSIZE = 3'd2,
    PH_RDATA = 3'd3,
    PH_WSIZE = 3'd4,
    PH_WDATA = 3'd5,
    PH_FIN   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] command_kind;
    logic [8:0] payload_length;
    logic       reload_timer;
    logic [7:0] rx_byte;
    logic [7:0] load_index;
    logic [7:0] load_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        size_valid;
    logic [15:0] response_size;
    logic [1:0]  status;
    logic [2:0]  error_code;
  } out_item_t;

  // Payload buffer access from the engine
  typedef struct packed {
    logic               we;
    logic [PBUF_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PBUF_AW-1:0] raddr;
  } pbuf_req_t;

endpackage

@@ sv/spist_payload_buf.sv @@
// Payload buffer memory with registered read and write-to-read forwarding.
`timescale 1ns / 1ps

module spist_payload_buf (
  input  logic                clk,
  input  spist_pkg::pbuf_req_t req,
  output logic [7:0]          rdata
);
  import spist_pkg::*;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rdata_r;

  // Store loaded bytes
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register read data; forward a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rdata_r <= req.wdata;
    end else begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/spi_slave_transaction_engine_unit.sv @@
// Top level of the slave-side byte exchange transaction engine.
`timescale 1ns / 1ps

// Slave-side exchange engine. Every input beat yields exactly one result beat.
// A beat passes an input register and is decided combinationally into the result
// register, so one beat is taken per clock unless out_stall holds a result. While
// a result waits, the input register still takes one more beat; the input is
// stalled only once both registers hold a beat. During a
// write phase the payload buffer is read ahead, at the address the byte counter
// will hold, so its registered read data is ready when the next
// received byte is decided. cfg_data is written to the timeout register
// whenever cfg_we is high; write it only while the block is idle.
module spi_slave_transaction_engine_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spist_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spist_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data
);
  import spist_pkg::*;

  // Pipeline registers
  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  out_item_t res_nxt;

  // Engine state
  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] size_r, size_nxt;
  logic [1:0]  armed_r, armed_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  timeout_r;

  logic        advance;
  logic        proc;
  logic [7:0]  pbuf_rdata;
  pbuf_req_t   pbuf_req;
  logic [15:0] cnt_inc;

  assign advance  = !out_vld_r || !out_stall;
  assign proc     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign cnt_inc  = cnt_r + 16'd1;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  // Decide one beat: next state and result
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    size_nxt  = size_r;
    armed_nxt = armed_r;
    ticks_nxt = ticks_r;
    run_nxt   = run_r;
    res_nxt   = '0;
    pbuf_req.we    = 1'b0;
    pbuf_req.waddr = PBUF_AW'(in_r.load_index);
    pbuf_req.wdata = in_r.load_byte;

    if (proc) begin
      case (in_r.cmd)
        CMD_START: begin
          armed_nxt = (in_r.command_kind == KIND_RSVD) ? KIND_END : in_r.command_kind;
          size_nxt  = (32'(in_r.payload_length) > PAYLOAD_DEPTH) ?
                      16'(PAYLOAD_DEPTH) : 16'(in_r.payload_length);
          cnt_nxt   = '0;
          phase_nxt = PH_TYPE;
          if (in_r.reload_timer) begin
            ticks_nxt = timeout_r;
            run_nxt   = 1'b1;
          end
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = NULL_BYTE;
        end
        CMD_RX: begin
          case (phase_r)
            PH_TYPE: begin
              if (in_r.rx_byte == TYPE_REQUEST) begin
                res_nxt.tx_valid = 1'b1;
                res_nxt.tx_byte  = CMD_BYTE_BASE + 8'(armed_r);
                if (armed_r == KIND_WRITE) begin
                  phase_nxt = PH_WSIZE;
                  cnt_nxt   = '0;
                end else begin
                  phase_nxt = PH_FIN;
                end
              end else if (in_r.rx_byte == TYPE_RESPONSE) begin
                res_nxt.tx_valid = 1'b1;
                res_nxt.tx_byte  = NULL_BYTE;
                phase_nxt = PH_RSIZE;
                cnt_nxt   = '0;
              end else begin
                phase_nxt          = PH_IDLE;
                res_nxt.status     = ST_ERR;
                res_nxt.error_code = ERR_TYPE;
              end
            end
            PH_RSIZE: begin
              // Size arrives low byte first
              if (cnt_r != 16'd0) begin
                size_nxt  = {in_r.rx_byte, size_r[7:0]};
                phase_nxt = PH_RDATA;
                cnt_nxt   = '0;
                res_nxt.size_valid    = 1'b1;
                res_nxt.response_size = {in_r.rx_byte, size_r[7:0]};
              end else begin
                size_nxt = {size_r[15:8], in_r.rx_byte};
                cnt_nxt  = 16'd1;
              end
              res_nxt.tx_valid = 1'b1;
              res_nxt.tx_byte  = NULL_BYTE;
            end
            PH_RDATA: begin
              if (cnt_r < size_r) begin
                res_nxt.data_valid = 1'b1;
                res_nxt.data_byte  = in_r.rx_byte;
              end
              cnt_nxt = cnt_inc;
              if (cnt_inc >= size_r) begin
                phase_nxt      = PH_IDLE;
                res_nxt.status = ST_OK;
              end else begin
                res_nxt.tx_valid = 1'b1;
                res_nxt.tx_byte  = NULL_BYTE;
              end
            end
            PH_WSIZE: begin
              res_nxt.tx_valid = 1'b1;
              if (cnt_r != 16'd0) begin
                res_nxt.tx_byte = size_r[15:8];
                phase_nxt = PH_WDATA;
                cnt_nxt   = '0;
              end else begin
                res_nxt.tx_byte = size_r[7:0];
                cnt_nxt = 16'd1;
              end
            end
            PH_WDATA: begin
              res_nxt.tx_valid = 1'b1;
              if ((cnt_r < size_r) && (32'(cnt_r) < PAYLOAD_DEPTH)) begin
                res_nxt.tx_byte = pbuf_rdata;
              end else begin
                res_nxt.tx_byte = NULL_BYTE;
              end
              cnt_nxt = cnt_inc;
              if (cnt_inc >= size_r) begin
                phase_nxt = PH_FIN;
              end
            end
            PH_FIN: begin
              phase_nxt      = PH_IDLE;
              res_nxt.status = ST_OK;
            end
            default: begin
              phase_nxt          = PH_IDLE;
              res_nxt.status     = ST_ERR;
              res_nxt.error_code = ERR_IDLE;
            end
          endcase
        end
        CMD_TICK: begin
          if (run_r) begin
            if (ticks_r <= 8'd1) begin
              ticks_nxt          = '0;
              run_nxt            = 1'b0;
              phase_nxt          = PH_IDLE;
              res_nxt.status     = ST_ERR;
              res_nxt.error_code = ERR_TIMEOUT;
            end else begin
              ticks_nxt = ticks_r - 8'd1;
            end
          end
        end
        CMD_PERR: begin
          phase_nxt          = PH_IDLE;
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_PIN;
        end
        CMD_LOAD: begin
          pbuf_req.we = 1'b1;
        end
        default: begin
          // Unused commands: all-zero result
        end
      endcase
    end

    // Prefetch the entry the counter will point at
    pbuf_req.raddr = PBUF_AW'(cnt_nxt);
  end

  // Engine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      size_r  <= '0;
      armed_r <= KIND_END;
      ticks_r <= '0;
      run_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      armed_r <= armed_nxt;
      ticks_r <= ticks_nxt;
      run_r   <= run_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  spist_payload_buf u_pbuf (
    .clk   (clk),
    .req   (pbuf_req),
    .rdata (pbuf_rdata)
  );

  // Checks
  a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status == ST_ERR) |-> (out_r.error_code != ERR_NONE))
    else $error("error result without an error code");

  a_code_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status != ST_ERR) |-> (out_r.error_code == ERR_NONE))
    else $error("error code on a non-error result");

  a_timer_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (ticks_r == 8'd0))
    else $error("stopped timer holds ticks");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc && (res_nxt.status != ST_OPEN) |=> (phase_r == PH_IDLE))
    else $error("phase not idle after end of phase");

endmodule

@@ test/spi_slave_transaction_engine_unit_tb.sv @@
// Testbench for the slave-side transaction engine: directed table, random exchanges, scoreboard.
`timescale 1ns / 1ps

module spi_slave_transaction_engine_unit_tb;
  import spist_pkg::*;

  localparam logic [2:0] CMD_UNUSED   = 3'd7;
  localparam int         RANDOM_BEATS = 850;
  localparam int         TMO_PHASES   = 5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] kind;
    logic [8:0] len;
    logic       reload;
    logic [7:0] rxb;
    logic [7:0] idx;
    logic [7:0] lb;
    logic       typed;
    logic       tx_v;
    logic [7:0] tx_b;
    logic [1:0] st;
    logic [2:0] err;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_data;

  // Shadow of the engine state
  phase_t      ph       = PH_IDLE;
  logic [15:0] cnt      = '0;
  logic [15:0] sz       = '0;
  logic [1:0]  armed    = KIND_END;
  logic [7:0]  ticks    = '0;
  logic        timer_on = 1'b0;
  logic [7:0]  tmo_reg  = TIMEOUT_RESET;
  logic [7:0]  pbuf [PAYLOAD_DEPTH];
  bit          loaded [PAYLOAD_DEPTH];

  out_item_t pending_results [$];
  int        bad_beats = 0;
  int        fed_beats = 0;
  bit        in_calm   = 1'b0;
  bit        out_calm  = 1'b0;

  spi_slave_transaction_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow state by one beat and return the result it causes
  function automatic out_item_t predict_exchange(in_item_t it);
    out_item_t r;
    logic [8:0] len;
    logic [7:0] b;
    r = '0;
    b = it.rx_byte;
    case (it.cmd)
      CMD_START: begin
        armed = (it.command_kind == KIND_RSVD) ? KIND_END : it.command_kind;
        len = (it.payload_length > PAYLOAD_DEPTH) ? 9'(PAYLOAD_DEPTH) : it.payload_length;
        sz = {7'd0, len};
        cnt = '0;
        ph = PH_TYPE;
        if (it.reload_timer) begin
          ticks = tmo_reg;
          timer_on = 1'b1;
        end
        r.tx_valid = 1'b1;
        r.tx_byte = NULL_BYTE;
      end
      CMD_RX: begin
        case (ph)
          PH_TYPE: begin
            if (b == TYPE_REQUEST) begin
              r.tx_valid = 1'b1;
              r.tx_byte = CMD_BYTE_BASE + 8'(armed);
              if (armed == KIND_WRITE) begin
                ph = PH_WSIZE;
                cnt = '0;
              end else begin
                ph = PH_FIN;
              end
            end else if (b == TYPE_RESPONSE) begin
              r.tx_valid = 1'b1;
              r.tx_byte = NULL_BYTE;
              ph = PH_RSIZE;
              cnt = '0;
            end else begin
              ph = PH_IDLE;
              r.status = ST_ERR;
              r.error_code = ERR_TYPE;
            end
          end
          PH_RSIZE: begin
            // Size arrives low byte first
            if (cnt != 0) begin
              sz = {b, sz[7:0]};
              ph = PH_RDATA;
              cnt = '0;
              r.size_valid = 1'b1;
              r.response_size = sz;
            end else begin
              sz = {sz[15:8], b};
              cnt = 16'd1;
            end
            r.tx_valid = 1'b1;
            r.tx_byte = NULL_BYTE;
          end
          PH_RDATA: begin
            if (cnt < sz) begin
              r.data_valid = 1'b1;
              r.data_byte = b;
            end
            cnt = cnt + 16'd1;
            if (cnt >= sz) begin
              ph = PH_IDLE;
              r.status = ST_OK;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = NULL_BYTE;
            end
          end
          PH_WSIZE: begin
            r.tx_valid = 1'b1;
            if (cnt != 0) begin
              r.tx_byte = sz[15:8];
              ph = PH_WDATA;
              cnt = '0;
            end else begin
              r.tx_byte = sz[7:0];
              cnt = 16'd1;
            end
          end
          PH_WDATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte = (cnt < sz && cnt < PAYLOAD_DEPTH) ? pbuf[cnt[7:0]] : NULL_BYTE;
            cnt = cnt + 16'd1;
            if (cnt >= sz) ph = PH_FIN;
          end
          PH_FIN: begin
            ph = PH_IDLE;
            r.status = ST_OK;
          end
          default: begin
            ph = PH_IDLE;
            r.status = ST_ERR;
            r.error_code = ERR_IDLE;
          end
        endcase
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (ticks <= 8'd1) begin
            ticks = '0;
            timer_on = 1'b0;
            ph = PH_IDLE;
            r.status = ST_ERR;
            r.error_code = ERR_TIMEOUT;
          end else begin
            ticks = ticks - 8'd1;
          end
        end
      end
      CMD_PERR: begin
        ph = PH_IDLE;
        r.status = ST_ERR;
        r.error_code = ERR_PIN;
      end
      CMD_LOAD: pbuf[it.load_index] = it.load_byte;
      default: ;
    endcase
    return r;
  endfunction

  // Count of buffer entries written without a hole, starting at entry 0
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < PAYLOAD_DEPTH && loaded[n]) n++;
    return n;
  endfunction

  // Beat of the given command with random content in every other field
  function automatic in_item_t beat_of(logic [2:0] c);
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic dir_row_t row(logic [2:0] cmd, logic [1:0] kind, logic [8:0] len,
                                   logic reload, logic [7:0] rxb, logic [7:0] idx,
                                   logic [7:0] lb, logic typed, logic tx_v,
                                   logic [7:0] tx_b, logic [1:0] st, logic [2:0] err);
    dir_row_t d;
    d = '{cmd, kind, len, reload, rxb, idx, lb, typed, tx_v, tx_b, st, err};
    return d;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then record its result
  task automatic push_beat(in_item_t it, logic typed, out_item_t typed_res);
    int gap;
    int pre;
    int clamped;
    out_item_t pred;
    // Never let a write phase read a buffer entry that was not loaded
    if (it.cmd == CMD_START && it.command_kind == KIND_WRITE) begin
      pre = loaded_prefix();
      clamped = (it.payload_length > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : it.payload_length;
      if (clamped > pre) it.payload_length = 9'($urandom_range(0, pre));
    end
    gap = in_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_exchange(it);
    if (it.cmd == CMD_LOAD) loaded[it.load_index] = 1'b1;
    pending_results.push_back(typed ? typed_res : pred);
    if (it.cmd <= CMD_LOAD) fed_beats++;
  endtask

  task automatic push_start(logic [1:0] kind, logic [8:0] len, logic reload);
    in_item_t it;
    it = beat_of(CMD_START);
    it.command_kind = kind;
    it.payload_length = len;
    it.reload_timer = reload;
    push_beat(it, 1'b0, '0);
  endtask

  // Received byte, now and then preceded by a timer tick
  task automatic push_rx(logic [7:0] b);
    in_item_t it;
    if ($urandom_range(0, 11) == 0) push_beat(beat_of(CMD_TICK), 1'b0, '0);
    it = beat_of(CMD_RX);
    it.rx_byte = b;
    push_beat(it, 1'b0, '0);
  endtask

  task automatic push_load(logic [7:0] idx, logic [7:0] b);
    in_item_t it;
    it = beat_of(CMD_LOAD);
    it.load_index = idx;
    it.load_byte = b;
    push_beat(it, 1'b0, '0);
  endtask

  // Drop valid and hold off until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tmo_reg = v;
  endtask

  // Result side: random stall before each beat, with calm stretches
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t: result beat with nothing expected: %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.tx_valid !== want.tx_valid || out_data.tx_byte !== want.tx_byte ||
            out_data.data_valid !== want.data_valid ||
            out_data.data_byte !== want.data_byte ||
            out_data.size_valid !== want.size_valid ||
            out_data.response_size !== want.response_size ||
            out_data.status !== want.status || out_data.error_code !== want.error_code) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display({"%0t: mismatch exp tx %b/%h data %b/%h size %b/%h st %0d err %0d",
                      " | got tx %b/%h data %b/%h size %b/%h st %0d err %0d"}, $time,
                     want.tx_valid, want.tx_byte, want.data_valid, want.data_byte,
                     want.size_valid, want.response_size, want.status, want.error_code,
                     out_data.tx_valid, out_data.tx_byte, out_data.data_valid,
                     out_data.data_byte, out_data.size_valid, out_data.response_size,
                     out_data.status, out_data.error_code);
        end
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("[spi_slave_transaction_engine_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   dir_tab [$];
    in_item_t   it;
    out_item_t  res;
    int         pick;
    int         n;
    int         len;
    int         phase_end;
    logic [15:0] rsz;
    logic [1:0] kind;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: idle errors, ignored beats, extremes, every command kind
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, TYPE_REQUEST, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_ERR, ERR_IDLE));
    dir_tab.push_back(row(CMD_TICK, KIND_RSVD, 9'd511, 1'b1, 8'hFF, 8'hFF, 8'hFF,
                          1'b1, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_PERR, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_ERR, ERR_PIN));
    dir_tab.push_back(row(CMD_UNUSED, KIND_RSVD, 9'd511, 1'b1, 8'hFF, 8'hFF, 8'hFF,
                          1'b1, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_LOAD, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'hFF,
                          1'b1, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_LOAD, KIND_END, 9'd0, 1'b0, 8'h00, 8'hFF, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_LOAD, KIND_END, 9'd0, 1'b0, 8'h00, 8'h01, 8'h5A,
                          1'b1, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    // end command with an over-long length
    dir_tab.push_back(row(CMD_START, KIND_END, 9'd511, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b1, NULL_BYTE, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, TYPE_REQUEST, 8'h00, 8'h00,
                          1'b1, 1'b1, CMD_BYTE_BASE, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'hFF, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_OK, ERR_NONE));
    // reserved kind goes out as the end command
    dir_tab.push_back(row(CMD_START, KIND_RSVD, 9'd0, 1'b1, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b1, NULL_BYTE, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, TYPE_REQUEST, 8'h00, 8'h00,
                          1'b1, 1'b1, CMD_BYTE_BASE, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_OK, ERR_NONE));
    // zero-length write: size bytes, one filler byte, then done
    dir_tab.push_back(row(CMD_START, KIND_WRITE, 9'd0, 1'b1, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, TYPE_REQUEST, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h12, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h34, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h56, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h78, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    // response announcing zero bytes: next byte is swallowed
    dir_tab.push_back(row(CMD_START, KIND_READ, 9'd256, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, TYPE_RESPONSE, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'hAB, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00, ST_OPEN, ERR_NONE));
    // bad type byte
    dir_tab.push_back(row(CMD_START, KIND_END, 9'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b1, NULL_BYTE, ST_OPEN, ERR_NONE));
    dir_tab.push_back(row(CMD_RX, KIND_END, 9'd0, 1'b0, 8'h52, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00, ST_ERR, ERR_TYPE));

    foreach (dir_tab[i]) begin
      it = '0;
      it.cmd = dir_tab[i].cmd;
      it.command_kind = dir_tab[i].kind;
      it.payload_length = dir_tab[i].len;
      it.reload_timer = dir_tab[i].reload;
      it.rx_byte = dir_tab[i].rxb;
      it.load_index = dir_tab[i].idx;
      it.load_byte = dir_tab[i].lb;
      res = '0;
      res.tx_valid = dir_tab[i].tx_v;
      res.tx_byte = dir_tab[i].tx_b;
      res.status = dir_tab[i].st;
      res.error_code = dir_tab[i].err;
      push_beat(it, dir_tab[i].typed, res);
    end

    // Random exchanges, one timeout setting per phase, idle between phases
    for (int p = 0; p < TMO_PHASES; p++) begin
      drain();
      case (p)
        0:       set_timeout(8'd1);
        1:       set_timeout(8'd255);
        2:       set_timeout(8'($urandom_range(2, 6)));
        3:       set_timeout(8'($urandom_range(1, 255)));
        default: set_timeout(TIMEOUT_RESET);
      endcase
      phase_end = fed_beats + RANDOM_BEATS / TMO_PHASES;
      while (fed_beats < phase_end) begin
        if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // extend the loaded part of the buffer
          n = $urandom_range(1, 12);
          len = loaded_prefix();
          if (len == PAYLOAD_DEPTH) len = $urandom_range(0, PAYLOAD_DEPTH - 1);
          for (int k = 0; k < n; k++)
            push_load(8'((len + k) % PAYLOAD_DEPTH), 8'($urandom_range(0, 255)));
        end else if (pick < 20) begin
          repeat ($urandom_range(1, 3))
            push_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 45) begin
          // write: command, size, payload, closing byte
          len = loaded_prefix();
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len)
                                              : $urandom_range(0, (len < 8) ? len : 8);
          push_start(KIND_WRITE, 9'(len), 1'($urandom_range(0, 1)));
          push_rx(TYPE_REQUEST);
          repeat (2) push_rx(8'($urandom_range(0, 255)));
          repeat ((len == 0) ? 1 : len) push_rx(8'($urandom_range(0, 255)));
          push_rx(8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
          // response: size, data; large sizes are cut short by the error pin
          push_start(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)));
          push_rx(TYPE_RESPONSE);
          rsz = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6))
                                            : 16'($urandom_range(0, 65535));
          push_rx(rsz[7:0]);
          push_rx(rsz[15:8]);
          if (rsz <= 16'd12) begin
            repeat ((rsz == 0) ? 1 : int'(rsz)) push_rx(8'($urandom_range(0, 255)));
          end else begin
            repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)));
            push_beat(beat_of(CMD_PERR), 1'b0, '0);
          end
        end else if (pick < 80) begin
          // read request or end command
          n = $urandom_range(0, 2);
          kind = (n == 2) ? KIND_RSVD : ((n == 1) ? KIND_READ : KIND_END);
          push_start(kind, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
          push_rx(TYPE_REQUEST);
          push_rx(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
          // broken exchanges: bad type, error pin mid-phase, timeout
          push_start(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)));
          case ($urandom_range(0, 2))
            0: push_rx(8'($urandom_range(0, 255)));
            1: begin
              push_rx(($urandom_range(0, 1) != 0) ? TYPE_REQUEST : TYPE_RESPONSE);
              push_beat(beat_of(CMD_PERR), 1'b0, '0);
            end
            default: begin
              push_start(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), 1'b1);
              repeat ($urandom_range(1, 12)) push_beat(beat_of(CMD_TICK), 1'b0, '0);
              push_rx(8'($urandom_range(0, 255)));
            end
          endcase
        end else begin
          repeat ($urandom_range(1, 4))
            push_beat(beat_of(3'($urandom_range(0, 7))), 1'b0, '0);
        end
      end
    end

    drain();
    if (bad_beats == 0 && pending_results.size() == 0)
      $display("[spi_slave_transaction_engine_unit] OK");
    else
      $display("[spi_slave_transaction_engine_unit] ERROR");
    $finish;
  end

endmodule
